>>> rtl/three_wire_register_access_master_macros.svh
// Assertion macros shared by the RTL files.
`ifndef THREE_WIRE_REGISTER_ACCESS_MASTER_MACROS_SVH
`define THREE_WIRE_REGISTER_ACCESS_MASTER_MACROS_SVH

// Holds at every clock edge while out of reset.
`define TWRAM_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define TWRAM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the next cycle.
`define TWRAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/twram_pkg.sv
`default_nettype none

package twram_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int BIT_TICKS     = 4 * BITS_PER_BYTE;
	localparam int CLOSE_PHASE   = BIT_TICKS + 1;
	localparam int PHASE_W       = 6;

	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_WRITE = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// One result transaction.
	typedef struct packed {
		logic                     chip_enable;
		logic                     serial_clock;
		logic                     data_pin_out;
		logic                     data_drive;
		logic                     busy_res;
		logic                     done_res;
		logic [BITS_PER_BYTE-1:0] read_value;
		logic                     rejected;
	} res_t;

	// Binary to BCD: v/10 via multiply by 205, shift by 11 (exact below 1029).
	function automatic logic [7:0] to_bcd(input logic [7:0] v);
		logic [15:0] prod;
		logic [4:0]  q;
		logic [7:0]  r;
		prod = {8'd0, v} * 16'd205;
		q    = prod[15:11];
		r    = v - ({3'd0, q} * 8'd10);
		return {q[3:0], r[3:0]};
	endfunction

	// BCD to binary, non-BCD digits just weighted by ten.
	function automatic logic [7:0] from_bcd(input logic [7:0] b);
		return ({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
	endfunction

endpackage

`default_nettype wire

>>> rtl/twram_seq.sv
`default_nettype none

`include "three_wire_register_access_master_macros.svh"

module twram_seq (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                step,
	input  wire logic [1:0]                          mode,
	input  wire logic [twram_pkg::BITS_PER_BYTE-1:0] command_byte,
	input  wire logic [twram_pkg::BITS_PER_BYTE-1:0] write_value,
	input  wire logic                                use_bcd,
	input  wire logic                                data_pin_in,
	output twram_pkg::res_t                          res
);
	import twram_pkg::*;

	localparam int SHIFT_W = 2 * BITS_PER_BYTE;

	logic [PHASE_W-1:0]       phase_q, phase_d;
	logic [SHIFT_W-1:0]       out_shift_q, out_shift_d;
	logic [BITS_PER_BYTE-1:0] in_shift_q, in_shift_d;
	logic                     is_read_q, is_read_d;
	logic                     bcd_q, bcd_d;
	logic                     clk_lvl_q, clk_lvl_d;

	logic                     is_start;
	logic [PHASE_W-1:0]       pm1;
	logic [BITS_PER_BYTE-1:0] wv;

	assign is_start = (mode == MODE_WRITE) || (mode == MODE_READ);
	assign pm1      = phase_q - PHASE_W'(1);

	always_comb begin
		phase_d     = phase_q;
		out_shift_d = out_shift_q;
		in_shift_d  = in_shift_q;
		is_read_d   = is_read_q;
		bcd_d       = bcd_q;
		clk_lvl_d   = clk_lvl_q;
		wv          = use_bcd ? to_bcd(write_value) : write_value;
		res         = '0;

		if (phase_q == '0) begin
			if (is_start) begin
				is_read_d      = (mode == MODE_READ);
				bcd_d          = use_bcd;
				out_shift_d    = (mode == MODE_READ) ? {{BITS_PER_BYTE{1'b0}}, command_byte}
				                                     : {wv, command_byte};
				in_shift_d     = '0;
				clk_lvl_d      = 1'b0;
				phase_d        = PHASE_W'(1);
				res.chip_enable = 1'b1;
				res.data_drive  = 1'b1;
				res.busy_res    = 1'b1;
			end
		end else begin
			res.rejected = is_start;
			if (phase_q <= PHASE_W'(BIT_TICKS)) begin
				res.chip_enable = 1'b1;
				res.busy_res    = 1'b1;
				// second byte of a read: line released, sample after falling edge
				if (is_read_q && (pm1 >= PHASE_W'(2 * BITS_PER_BYTE))) begin
					if (!pm1[0]) begin
						clk_lvl_d = 1'b1;
					end else begin
						clk_lvl_d  = 1'b0;
						in_shift_d = {data_pin_in, in_shift_q[BITS_PER_BYTE-1:1]};
					end
				end else begin
					res.data_drive   = 1'b1;
					res.data_pin_out = out_shift_q[0];
					if (!pm1[0]) begin
						clk_lvl_d = 1'b0;
					end else begin
						clk_lvl_d   = 1'b1;
						out_shift_d = {1'b0, out_shift_q[SHIFT_W-1:1]};
					end
				end
				phase_d = phase_q + PHASE_W'(1);
			end else begin
				// closing tick
				clk_lvl_d    = 1'b1;
				res.done_res = 1'b1;
				if (is_read_q) begin
					res.read_value = bcd_q ? from_bcd(in_shift_q) : in_shift_q;
				end
				phase_d = '0;
			end
		end
		res.serial_clock = clk_lvl_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			out_shift_q <= '0;
			in_shift_q  <= '0;
			is_read_q   <= 1'b0;
			bcd_q       <= 1'b0;
			clk_lvl_q   <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			out_shift_q <= out_shift_d;
			in_shift_q  <= in_shift_d;
			is_read_q   <= is_read_d;
			bcd_q       <= bcd_d;
			clk_lvl_q   <= clk_lvl_d;
		end
	end

	`TWRAM_ASSERT_ALWAYS(a_phase_range, clk, arst_n, phase_q <= PHASE_W'(CLOSE_PHASE), "phase out of range")
	`TWRAM_ASSERT_NEXT(a_close_idle, clk, arst_n, step && (phase_q == PHASE_W'(CLOSE_PHASE)), phase_q == '0, "close did not return to idle")

endmodule

`default_nettype wire

>>> rtl/three_wire_register_access_master.sv
// Three-wire register access master: drives chip enable, serial clock and a
// bidirectional data line toward a clock chip. Every input transaction is one
// half-bit tick of the link (mode 0) or a request to open a register write
// (mode 1) or read (mode 2); each accepted transaction yields exactly one result
// transaction carrying the line levels for that tick plus busy, done, rejected
// and, on the closing tick of a read, the byte read. A frame is one start tick,
// 32 bit ticks (command byte then data byte, LSB first, two ticks per bit) and
// one closing tick, so 34 transactions per register access. Throughput is one
// transaction per clock while in_stall is low: the frame sequencer state
// updates as each transaction is accepted and the result is registered into a two-entry output buffer
// (output register plus skid register), so in_stall only rises once both
// entries hold results the downstream has not yet taken.
`default_nettype none

`include "three_wire_register_access_master_macros.svh"

module three_wire_register_access_master (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          mode,
	input  wire logic [twram_pkg::BITS_PER_BYTE-1:0] command_byte,
	input  wire logic [twram_pkg::BITS_PER_BYTE-1:0] write_value,
	input  wire logic                                use_bcd,
	input  wire logic                                data_pin_in,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     chip_enable,
	output logic                                     serial_clock,
	output logic                                     data_pin_out,
	output logic                                     data_drive,
	output logic                                     busy_res,
	output logic                                     done_res,
	output logic [twram_pkg::BITS_PER_BYTE-1:0]      read_value,
	output logic                                     rejected
);
	import twram_pkg::*;

	logic acc_in;
	logic drain;
	res_t step_res;

	// output buffer: main entry drives the ports, skid catches one extra
	res_t out_q, skid_q;
	logic out_valid_q, skid_valid_q;

	assign in_stall = skid_valid_q;
	assign acc_in   = in_valid && !in_stall;
	assign drain    = out_valid_q && !out_stall;

	twram_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (acc_in),
		.mode         (mode),
		.command_byte (command_byte),
		.write_value  (write_value),
		.use_bcd      (use_bcd),
		.data_pin_in  (data_pin_in),
		.res          (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (acc_in) begin
				// skid is empty whenever a transaction is accepted
				if (!out_valid_q || drain) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (drain) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	// payload: no reset needed
	always_ff @(posedge clk) begin
		if (acc_in) begin
			if (!out_valid_q || drain) begin
				out_q <= step_res;
			end else begin
				skid_q <= step_res;
			end
		end else if (drain && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign chip_enable  = out_q.chip_enable;
	assign serial_clock = out_q.serial_clock;
	assign data_pin_out = out_q.data_pin_out;
	assign data_drive   = out_q.data_drive;
	assign busy_res     = out_q.busy_res;
	assign done_res     = out_q.done_res;
	assign read_value   = out_q.read_value;
	assign rejected     = out_q.rejected;

	`TWRAM_ASSERT_IMPLY(a_skid_behind_out, clk, arst_n, skid_valid_q, out_valid_q, "skid full with output empty")
	`TWRAM_ASSERT_IMPLY(a_busy_is_ce, clk, arst_n, out_valid_q, busy_res == chip_enable, "busy and chip enable disagree")
	`TWRAM_ASSERT_IMPLY(a_done_closes, clk, arst_n, out_valid_q && done_res, !chip_enable && !data_drive && serial_clock, "closing tick line levels wrong")
	`TWRAM_ASSERT_IMPLY(a_released_low, clk, arst_n, out_valid_q && !data_drive, !data_pin_out, "data level set while released")

endmodule

`default_nettype wire
